/* rtl/tcw_pkg.sv */
// tcw_pkg: shared types, codes and constants for the text console writer
// no dependencies; every other file of the block refers to it by scoped names
`default_nettype none

package tcw_pkg;

    // default screen geometry, handed down from the top level parameters
    localparam int COLS_DEF     = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STEP_DEF = 8;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    // fixed field widths of the channels
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int RROW_W  = 5;
    localparam int RCOL_W  = 7;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;
    localparam int CADDR_W = 11;

    // attribute after reset, used by the power-up blanking pass
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // input mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_BKSP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    // classified operations passed from front to back
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_BKSP,
        OP_CLEAR,
        OP_READ
    } t_op;

    // classified command (the linear read offset travels beside it)
    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic              in_range;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_CLR,
        ST_SCROLL,
        ST_TAB,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/tcw_channels.sv */
// tcw_channels: valid/ready channel interfaces of the text console writer
// depends on tcw_pkg for the field widths
`default_nettype none

// input item channel
interface tcw_in_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::MODE_W-1:0] mode;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::RROW_W-1:0] read_row;
    logic [tcw_pkg::RCOL_W-1:0] read_col;

    modport source (output valid, mode, char_code, read_row, read_col, input ready);
    modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

// result item channel
interface tcw_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CROW_W-1:0]  cursor_row;
    logic [tcw_pkg::CCOL_W-1:0]  cursor_col;
    logic [tcw_pkg::CADDR_W-1:0] cursor_address;
    logic [tcw_pkg::CHAR_W-1:0]  cell_char;
    logic [tcw_pkg::COLOR_W-1:0] cell_color;

    modport source (output valid, cursor_row, cursor_col, cursor_address,
                    cell_char, cell_color, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_address,
                    cell_char, cell_color, output ready);
endinterface

// colour register write channel
interface tcw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::COLOR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/tcw_front.sv */
// tcw_front: accepts input items and classifies them into back-end commands
// depends on tcw_pkg and the tcw_in_if interface
`default_nettype none

module tcw_front #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    tcw_in_if.sink                          i_in,
    input  wire logic                       i_q_full,
    input  wire logic                       i_init_busy,
    output tcw_pkg::t_cmd                   o_cmd,
    output logic [$clog2(ROWS*COLS)-1:0]    o_lin,
    output logic                            o_push
);

    localparam int AW = $clog2(ROWS*COLS);

    logic row_ok;
    logic col_ok;

    // no items during the power-up blanking pass or with a full queue
    assign i_in.ready = !i_q_full && !i_init_busy;
    assign o_push     = i_in.valid && i_in.ready;

    // read coordinates checked against the screen size
    assign row_ok = 7'(i_in.read_row) < 7'(ROWS);
    assign col_ok = 8'(i_in.read_col) < 8'(COLS);

    // classify the item
    always_comb begin
        o_cmd.op       = tcw_pkg::OP_CHAR;
        o_cmd.ch       = i_in.char_code;
        o_cmd.in_range = 1'b0;
        o_lin          = '0;
        unique case (tcw_pkg::t_mode'(i_in.mode))
            tcw_pkg::MODE_PUT: begin
                if (i_in.char_code == tcw_pkg::CH_NEWLINE) begin
                    o_cmd.op = tcw_pkg::OP_NEWLINE;
                end else if (i_in.char_code == tcw_pkg::CH_TAB) begin
                    o_cmd.op = tcw_pkg::OP_TAB;
                end else begin
                    o_cmd.op = tcw_pkg::OP_CHAR;
                end
            end
            tcw_pkg::MODE_BKSP: begin
                o_cmd.op = tcw_pkg::OP_BKSP;
            end
            tcw_pkg::MODE_CLEAR: begin
                o_cmd.op = tcw_pkg::OP_CLEAR;
            end
            tcw_pkg::MODE_READ: begin
                o_cmd.op       = tcw_pkg::OP_READ;
                o_cmd.in_range = row_ok && col_ok;
                // logical linear offset of the cell, before the scroll rotation
                if (row_ok && col_ok) begin
                    o_lin = AW'(i_in.read_row) * AW'(COLS) + AW'(i_in.read_col);
                end
            end
            default: begin
                o_cmd.op = tcw_pkg::OP_CHAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tcw_queue.sv */
// tcw_queue: short first-in first-out queue between front and back
// depends on tcw_pkg only through the depth handed down from the top level
`default_nettype none

module tcw_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = tcw_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [NW-1:0]     r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == NW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill level update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
// tcw_back: executes commands on the screen memory, keeps the cursor, drives results
// depends on tcw_pkg and the tcw_out_if interface
`default_nettype none

module tcw_back #(
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire tcw_pkg::t_cmd                   i_cmd,
    input  wire logic [$clog2(ROWS*COLS)-1:0]    i_lin,
    output logic                                 o_q_pop,
    input  wire logic [tcw_pkg::COLOR_W-1:0]     i_color,
    output logic                                 o_init_busy,
    tcw_out_if.source                            o_out
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int TW    = $clog2(COLS + TAB_STEP);

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_op    r_op, n_op;
    logic            r_in_range, n_in_range;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_lrow, n_lrow;    // logical row start, row * COLS
    logic [AW-1:0]   r_prow, n_prow;    // physical row start of the cursor row
    logic [AW-1:0]   r_base, n_base;    // physical row start of the top row
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [TW-1:0]   r_tab, n_tab;
    logic [15:0]     r_rdata;
    logic [15:0]     mem [CELLS];

    logic            we;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdata;
    logic            rd_en;
    logic [AW:0]     rd_sum;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   bk_col;
    logic [15:0]     blank;
    logic            adv;
    logic            row_last;
    logic            col_last;
    logic            tab_wrap;
    logic            sweep_last;
    logic            scroll_last;
    logic            out_free;
    logic            out_load;

    logic                        r_out_valid;
    logic [tcw_pkg::CROW_W-1:0]  r_o_row;
    logic [tcw_pkg::CCOL_W-1:0]  r_o_col;
    logic [tcw_pkg::CADDR_W-1:0] r_o_addr;
    logic [tcw_pkg::CHAR_W-1:0]  r_o_char;
    logic [tcw_pkg::COLOR_W-1:0] r_o_color;

    // status terms
    assign row_last    = r_row == RW'(ROWS-1);
    assign col_last    = r_col == CW'(COLS-1);
    assign tab_wrap    = r_tab >= TW'(COLS);
    assign sweep_last  = r_cnt == AW'(CELLS-1);
    assign scroll_last = r_cnt == AW'(COLS-1);
    assign out_free    = !r_out_valid || o_out.ready;
    assign out_load    = (r_state == tcw_pkg::ST_DONE) && out_free;
    assign blank       = {i_color, tcw_pkg::CH_SPACE};
    assign bk_col      = (r_col != '0) ? r_col - 1'b1 : r_col;
    assign o_init_busy = r_state == tcw_pkg::ST_INIT_CLR;

    // read address: logical offset rotated by the scroll base
    assign rd_sum  = {1'b0, i_lin} + {1'b0, r_base};
    assign rd_addr = (rd_sum >= (AW+1)'(CELLS)) ? AW'(rd_sum - (AW+1)'(CELLS)) : AW'(rd_sum);

    // queue pop and row advance requests
    always_comb begin
        o_q_pop = 1'b0;
        adv     = 1'b0;
        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
                adv     = i_q_valid && (((i_cmd.op == tcw_pkg::OP_CHAR) && col_last) ||
                                        (i_cmd.op == tcw_pkg::OP_NEWLINE));
            end
            tcw_pkg::ST_TAB: begin
                adv = tab_wrap;
            end
            default: begin
                adv = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_INIT_CLR: begin
                if (sweep_last) n_state = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_cmd.op)
                        tcw_pkg::OP_CHAR, tcw_pkg::OP_NEWLINE: begin
                            n_state = (adv && row_last) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
                        end
                        tcw_pkg::OP_TAB:   n_state = tcw_pkg::ST_TAB;
                        tcw_pkg::OP_CLEAR: n_state = tcw_pkg::ST_CLR;
                        default:           n_state = tcw_pkg::ST_DONE;
                    endcase
                end
            end
            tcw_pkg::ST_TAB: begin
                if (!tab_wrap) begin
                    n_state = tcw_pkg::ST_DONE;
                end else if (row_last) begin
                    n_state = tcw_pkg::ST_SCROLL;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                if (scroll_last) begin
                    n_state = (r_op == tcw_pkg::OP_TAB) ? tcw_pkg::ST_TAB : tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_CLR: begin
                if (sweep_last) n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (out_free) n_state = tcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // cursor, counters and latched command
    always_comb begin
        n_op       = r_op;
        n_in_range = r_in_range;
        n_row      = r_row;
        n_col      = r_col;
        n_lrow     = r_lrow;
        n_prow     = r_prow;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_tab      = r_tab;
        unique case (r_state)
            tcw_pkg::ST_INIT_CLR, tcw_pkg::ST_SCROLL: begin
                n_cnt = r_cnt + 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_op       = i_cmd.op;
                    n_in_range = i_cmd.in_range;
                    unique case (i_cmd.op)
                        tcw_pkg::OP_CHAR:    n_col = col_last ? '0 : r_col + 1'b1;
                        tcw_pkg::OP_NEWLINE: n_col = '0;
                        tcw_pkg::OP_TAB:     n_tab = TW'(r_col) + TW'(TAB_STEP);
                        tcw_pkg::OP_BKSP:    n_col = bk_col;
                        tcw_pkg::OP_CLEAR:   n_cnt = '0;
                        default:             n_col = r_col;
                    endcase
                end
            end
            tcw_pkg::ST_TAB: begin
                if (tab_wrap) begin
                    n_tab = r_tab - TW'(COLS);
                end else begin
                    n_col = CW'(r_tab);
                end
            end
            tcw_pkg::ST_CLR: begin
                n_cnt = r_cnt + 1'b1;
                if (sweep_last) begin
                    n_row  = '0;
                    n_col  = '0;
                    n_lrow = '0;
                    n_prow = '0;
                    n_base = '0;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
        // next row: the physical row always steps; on the bottom row the screen rotates
        if (adv) begin
            n_prow = (r_prow == AW'(CELLS-COLS)) ? '0 : r_prow + AW'(COLS);
            if (row_last) begin
                n_base = (r_base == AW'(CELLS-COLS)) ? '0 : r_base + AW'(COLS);
                n_cnt  = '0;
            end else begin
                n_row  = r_row + 1'b1;
                n_lrow = r_lrow + AW'(COLS);
            end
        end
    end

    // memory port controls
    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = blank;
        rd_en = 1'b0;
        unique case (r_state)
            tcw_pkg::ST_INIT_CLR: begin
                we    = 1'b1;
                wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::ST_CLR: begin
                we = 1'b1;
            end
            tcw_pkg::ST_SCROLL: begin
                we    = 1'b1;
                waddr = r_prow + r_cnt;
            end
            tcw_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_cmd.op)
                        tcw_pkg::OP_CHAR: begin
                            we    = 1'b1;
                            waddr = r_prow + AW'(r_col);
                            wdata = {i_color, i_cmd.ch};
                        end
                        tcw_pkg::OP_BKSP: begin
                            we    = 1'b1;
                            waddr = r_prow + AW'(bk_col);
                        end
                        tcw_pkg::OP_READ: begin
                            rd_en = 1'b1;
                        end
                        default: begin
                            we = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcw_pkg::ST_INIT_CLR;
            r_op       <= tcw_pkg::OP_CHAR;
            r_in_range <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_lrow     <= '0;
            r_prow     <= '0;
            r_base     <= '0;
            r_cnt      <= '0;
            r_tab      <= '0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_in_range <= n_in_range;
            r_row      <= n_row;
            r_col      <= n_col;
            r_lrow     <= n_lrow;
            r_prow     <= n_prow;
            r_base     <= n_base;
            r_cnt      <= n_cnt;
            r_tab      <= n_tab;
        end
    end

    // screen memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_row   <= tcw_pkg::CROW_W'(r_row);
            r_o_col   <= tcw_pkg::CCOL_W'(r_col);
            r_o_addr  <= tcw_pkg::CADDR_W'(r_lrow + AW'(r_col));
            r_o_char  <= r_in_range ? r_rdata[7:0] : '0;
            r_o_color <= r_in_range ? r_rdata[15:8] : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cursor_row     = r_o_row;
    assign o_out.cursor_col     = r_o_col;
    assign o_out.cursor_address = r_o_addr;
    assign o_out.cell_char      = r_o_char;
    assign o_out.cell_color     = r_o_color;

    // cursor stays on the screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < (CW+1)'(COLS))
        else $error("cursor column beyond the width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < (RW+1)'(ROWS))
        else $error("cursor row beyond the height");

    // incremental row start tracks the row
    a_lrow_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lrow == AW'(AW'(r_row) * AW'(COLS)))
        else $error("logical row start out of step with the row");

    // physical row start stays inside the memory
    a_prow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_prow} < (AW+1)'(CELLS))
        else $error("physical row start beyond the memory");

    // no result while the power-up blanking pass runs
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_INIT_CLR) |-> !r_out_valid)
        else $error("result offered during the power-up pass");

endmodule

`default_nettype wire

/* rtl/text_console_writer_core.sv */
// text_console_writer_core: top level of the text console writer
// depends on tcw_pkg, tcw_channels, tcw_front, tcw_queue and tcw_back
//
// A character screen of ROWS x COLS cells (character low byte, attribute high byte) with a
// cursor; every input item gives exactly one result with the cursor position, its linear
// address and, for a read, the cell. After reset a blanking pass over the whole screen
// runs before the first item is taken; colour writes are taken at any time.
// The front classifies items into a two-entry queue; the back runs them against a screen
// memory with one write and one registered read port. A tab moves the cursor TAB_STEP
// columns on, wrapping onto the following rows, a scroll blanks the new bottom row (the
// screen rotates through a row base, nothing is copied) and a clear blanks the whole screen.
// The result sits in an output register, so the next item is taken while it waits.
`default_nettype none

module text_console_writer_core #(
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out,
    tcw_cfg_if.sink    i_cfg
);

    localparam int AW     = $clog2(ROWS*COLS);
    localparam int DATA_W = $bits(tcw_pkg::t_cmd) + AW;

    logic [tcw_pkg::COLOR_W-1:0] r_color;
    tcw_pkg::t_cmd               f_cmd;
    tcw_pkg::t_cmd               q_cmd;
    logic [AW-1:0]               f_lin;
    logic [AW-1:0]               q_lin;
    logic                        f_push;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        init_busy;
    logic [DATA_W-1:0]           q_out;

    // colour register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tcw_pkg::RESET_COLOR;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_color <= i_cfg.data;
        end
    end

    // front: accept and classify
    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_in        (i_in),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_cmd       (f_cmd),
        .o_lin       (f_lin),
        .o_push      (f_push)
    );

    // command queue
    tcw_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (tcw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cmd, f_lin}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign {q_cmd, q_lin} = q_out;

    // back: screen memory, cursor and results
    tcw_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .i_lin       (q_lin),
        .o_q_pop     (q_pop),
        .i_color     (r_color),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
